// ===== rtl/core/esc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// esc_pkg
// Shared constants for the environmental sensor compensation pipeline.
// ----------------------------------------------------------------------------
package esc_pkg;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] REG_TEMP   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PLOW   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_PHIGH  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_PNINE  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_HUM    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_HSIX   = 3'd5;

  localparam logic [63:0] TFINE_PRESS_OFFSET = 64'd128000;
  localparam logic [63:0] PRESS_BASE         = 64'd1048576;
  localparam logic [63:0] PRESS_SCALE        = 64'd3125;
  localparam logic [31:0] TFINE_HUM_OFFSET   = 32'd76800;
  localparam logic [31:0] HUM_CLAMP_HIGH     = 32'd419430400;
  localparam logic [31:0] HUM_BIAS_A         = 32'd2097152;
  localparam logic [31:0] HUM_ROUND_A        = 32'd16384;
  localparam logic [31:0] HUM_BIAS_B         = 32'd32768;
  localparam logic [31:0] HUM_ROUND_B        = 32'd8192;

  localparam int unsigned DivW = 64;

endpackage
`default_nettype wire

// ===== rtl/core/env_sensor_compensation.sv =====
`default_nettype none
// Throughput: one reading set per cycle while not stalled; the 64-stage
// divider pipeline makes up most of the pipeline depth.
// Output stalls freeze the whole pipeline (global enable); in_tready high
// while the output slot is free or being taken.
// Reset (synchronous, rst_n low) clears valid bits and coefficients.
// ----------------------------------------------------------------------------
// env_sensor_compensation
// Temperature, pressure and humidity compensation in a deep pipeline.
// ----------------------------------------------------------------------------
module env_sensor_compensation (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  // raw_temp[19:0], raw_press[39:20], raw_hum[55:40]
  input  wire logic [55:0]                  in_tdata,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  // temperature[31:0], pressure[63:32], humidity[80:64], pad
  output logic      [87:0]                  out_tdata,
  // pressure_invalid
  output logic                              out_tuser,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [esc_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [63:0]                  cfg_data
);
  import esc_pkg::*;

  localparam int unsigned NPre  = 8;
  localparam int unsigned NPost = 9;
  localparam int unsigned NV    = NPre + DivW + NPost;

  logic [47:0] tc_r;
  logic [63:0] pl_r, ph_r, hc_r;
  logic [15:0] p9_r;
  logic [7:0]  h6_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tc_r <= '0; pl_r <= '0; ph_r <= '0; p9_r <= '0; hc_r <= '0; h6_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TEMP:  tc_r <= cfg_data[47:0];
        REG_PLOW:  pl_r <= cfg_data;
        REG_PHIGH: ph_r <= cfg_data;
        REG_PNINE: p9_r <= cfg_data[15:0];
        REG_HUM:   hc_r <= cfg_data;
        REG_HSIX:  h6_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  logic [31:0] t1, t2, t3;
  logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0] h1, h2, h3, h4, h5, h6;
  assign t1 = {16'd0, tc_r[15:0]};
  assign t2 = {{16{tc_r[31]}}, tc_r[31:16]};
  assign t3 = {{16{tc_r[47]}}, tc_r[47:32]};
  assign p1 = {48'd0, pl_r[15:0]};
  assign p2 = {{48{pl_r[31]}}, pl_r[31:16]};
  assign p3 = {{48{pl_r[47]}}, pl_r[47:32]};
  assign p4 = {{48{pl_r[63]}}, pl_r[63:48]};
  assign p5 = {{48{ph_r[15]}}, ph_r[15:0]};
  assign p6 = {{48{ph_r[31]}}, ph_r[31:16]};
  assign p7 = {{48{ph_r[47]}}, ph_r[47:32]};
  assign p8 = {{48{ph_r[63]}}, ph_r[63:48]};
  assign p9 = {{48{p9_r[15]}}, p9_r};
  assign h1 = {24'd0, hc_r[7:0]};
  assign h2 = {{16{hc_r[23]}}, hc_r[23:8]};
  assign h3 = {24'd0, hc_r[31:24]};
  assign h4 = {{16{hc_r[47]}}, hc_r[47:32]};
  assign h5 = {{16{hc_r[63]}}, hc_r[63:48]};
  assign h6 = {{24{h6_r[7]}}, h6_r};

  // global enable: advance unless the output holds a beat not taken
  logic en;
  logic [NV-1:0] v_r;
  assign en = !out_tvalid || out_tready;
  assign in_tready = en;
  assign out_tvalid = v_r[NV-1];

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (en) v_r <= {v_r[NV-2:0], in_tvalid};
  end

  // ---- pre-divide stages ----
  // S1: capture, temp first terms
  logic [31:0] s1_ah, s1_ta, s1_d;
  logic [19:0] s1_ap;
  always_ff @(posedge clk) if (en) begin
    s1_ap <= in_tdata[39:20];
    s1_ah <= {16'd0, in_tdata[55:40]};
    s1_ta <= {15'd0, in_tdata[19:3]} - (t1 << 1);
    s1_d  <= {16'd0, in_tdata[19:4]} - t1;
  end
  // S2: products
  logic [31:0] s2_a, s2_dd, s2_ah;
  logic [19:0] s2_ap;
  always_ff @(posedge clk) if (en) begin
    s2_a  <= s1_ta * t2;
    s2_dd <= s1_d * s1_d;
    s2_ap <= s1_ap; s2_ah <= s1_ah;
  end
  // S3
  logic [31:0] s3_a, s3_b, s3_ah;
  logic [19:0] s3_ap;
  always_ff @(posedge clk) if (en) begin
    s3_a <= $signed(s2_a) >>> 11;
    s3_b <= 32'($signed(s2_dd) >>> 12) * t3;
    s3_ap <= s2_ap; s3_ah <= s2_ah;
  end
  // S4: tfine
  logic [31:0] s4_tf, s4_ah;
  logic [19:0] s4_ap;
  always_ff @(posedge clk) if (en) begin
    s4_tf <= s3_a + 32'($signed(s3_b) >>> 14);
    s4_ap <= s3_ap; s4_ah <= s3_ah;
  end
  // S5: v1, temp out, humidity h
  logic [63:0] s5_v1;
  logic [31:0] s5_temp, s5_h, s5_ah;
  logic [19:0] s5_ap;
  always_ff @(posedge clk) if (en) begin
    s5_v1 <= {{32{s4_tf[31]}}, s4_tf} - TFINE_PRESS_OFFSET;
    s5_temp <= 32'($signed(s4_tf * 32'd5 + 32'd128) >>> 8);
    s5_h <= s4_tf - TFINE_HUM_OFFSET;
    s5_ap <= s4_ap; s5_ah <= s4_ah;
  end
  // S6: squares and linear products; v1 fits in 33 signed bits
  logic signed [32:0] s5_v1s;
  logic signed [65:0] s5_vvw;
  assign s5_v1s = s5_v1[32:0];
  assign s5_vvw = s5_v1s * s5_v1s;
  logic [63:0] s6_vv, s6_v5, s6_v2;
  logic [31:0] s6_temp, s6_h, s6_ah;
  logic [19:0] s6_ap;
  always_ff @(posedge clk) if (en) begin
    s6_vv <= s5_vvw[63:0];
    s6_v5 <= s5_v1 * p5;
    s6_v2 <= s5_v1 * p2;
    s6_temp <= s5_temp; s6_h <= s5_h; s6_ah <= s5_ah; s6_ap <= s5_ap;
  end
  // S7
  logic [63:0] s7_v2, s7_v1;
  logic [31:0] s7_temp, s7_h, s7_ah;
  logic [19:0] s7_ap;
  always_ff @(posedge clk) if (en) begin
    s7_v2 <= s6_vv * p6 + (s6_v5 << 17) + (p4 << 35);
    s7_v1 <= 64'($signed(s6_vv * p3) >>> 8) + (s6_v2 << 12);
    s7_temp <= s6_temp; s7_h <= s6_h; s7_ah <= s6_ah; s7_ap <= s6_ap;
  end
  // S8: divisor and dividend
  logic [63:0] s8_den, s8_num, s8_pr;
  logic [31:0] s8_temp, s8_h, s8_ah;
  always_ff @(posedge clk) if (en) begin
    s8_den <= 64'($signed(((64'd1 << 47) + s7_v1) * p1) >>> 33);
    s8_pr  <= (((PRESS_BASE - {44'd0, s7_ap}) << 31) - s7_v2) * PRESS_SCALE;
    s8_temp <= s7_temp; s8_h <= s7_h; s8_ah <= s7_ah;
  end
  assign s8_num = s8_pr;

  // divider side payload: sign, zero flag, temp, h, ah
  localparam int unsigned SW = 2 + 32 + 32 + 16;
  logic nn, nd;
  logic [63:0] mn, md;
  assign nn = s8_num[63];
  assign nd = s8_den[63];
  assign mn = nn ? 64'(0) - s8_num : s8_num;
  assign md = nd ? 64'(0) - s8_den : s8_den;
  logic [SW-1:0] sd_in, sd_out;
  logic [63:0] uq;
  assign sd_in = {nn ^ nd, s8_den == '0, s8_temp, s8_h, s8_ah[15:0]};

  esc_div #(.SideW(SW)) u_div (
    .clk(clk), .en(en), .num(mn), .den(md), .side_in(sd_in),
    .quo(uq), .side_out(sd_out)
  );

  // ---- post-divide stages; humidity runs here too ----
  logic [63:0] q0;
  assign q0 = sd_out[SW-1] ? 64'(0) - uq : uq;

  logic [63:0] a1_pr, a1_sh;
  logic [31:0] a1_temp, a1_h, a1_x0, a1_y;
  logic a1_inv;
  logic [31:0] a1_ah;
  always_ff @(posedge clk) if (en) begin
    a1_pr <= q0;
    a1_sh <= 64'($signed(q0) >>> 13);
    a1_inv <= sd_out[SW-2];
    a1_temp <= sd_out[79:48];
    a1_h <= sd_out[47:16];
    a1_ah <= {16'd0, sd_out[15:0]};
    a1_x0 <= h5 * sd_out[47:16];
    a1_y <= 32'($signed(sd_out[47:16] * h6) >>> 10);
  end
  // square modulo 2^64 from 32-bit halves
  logic [63:0] a1_ll;
  logic [31:0] a1_lh;
  assign a1_ll = 64'(a1_sh[31:0]) * 64'(a1_sh[31:0]);
  assign a1_lh = a1_sh[31:0] * a1_sh[63:32];
  logic [63:0] a2_pr, a2_ll, a2_p8;
  logic [31:0] a2_lh, a2_temp, a2_x, a2_y, a2_z;
  logic a2_inv;
  always_ff @(posedge clk) if (en) begin
    a2_pr <= a1_pr; a2_inv <= a1_inv; a2_temp <= a1_temp;
    a2_ll <= a1_ll;
    a2_lh <= a1_lh;
    a2_p8 <= p8 * a1_pr;
    a2_x <= 32'($signed((a1_ah << 14) - (h4 << 20) - a1_x0 + HUM_ROUND_A) >>> 15);
    a2_y <= a1_y;
    a2_z <= 32'($signed(a1_h * h3) >>> 11) + HUM_BIAS_B;
  end
  logic [63:0] a3_pr, a3_v1, a3_v2;
  logic [31:0] a3_temp, a3_x, a3_yz;
  logic a3_inv;
  always_ff @(posedge clk) if (en) begin
    a3_pr <= a2_pr; a3_inv <= a2_inv; a3_temp <= a2_temp; a3_x <= a2_x;
    a3_v1 <= 64'($signed((a2_ll + {a2_lh[30:0], 33'd0}) * p9) >>> 25);
    a3_v2 <= 64'($signed(a2_p8) >>> 19);
    a3_yz <= a2_y * a2_z;
  end
  logic [31:0] a4_temp, a4_x, a4_w, a4_po;
  logic a4_inv;
  always_ff @(posedge clk) if (en) begin
    a4_temp <= a3_temp; a4_inv <= a3_inv; a4_x <= a3_x;
    a4_po <= a3_inv ? 32'd0 : 32'(64'($signed(a3_pr + a3_v1 + a3_v2) >>> 8)
             + (p7 << 4));
    a4_w <= 32'($signed(a3_yz) >>> 10) + HUM_BIAS_A;
  end
  logic [31:0] a5_temp, a5_x, a5_wh, a5_po;
  logic a5_inv;
  always_ff @(posedge clk) if (en) begin
    a5_temp <= a4_temp; a5_inv <= a4_inv; a5_x <= a4_x; a5_po <= a4_po;
    a5_wh <= a4_w * h2 + HUM_ROUND_B;
  end
  logic [31:0] a6_temp, a6_hh, a6_po;
  logic a6_inv;
  always_ff @(posedge clk) if (en) begin
    a6_temp <= a5_temp; a6_inv <= a5_inv; a6_po <= a5_po;
    a6_hh <= a5_x * 32'($signed(a5_wh) >>> 14);
  end
  logic [31:0] a7_temp, a7_hh, a7_sq, a7_po;
  logic a7_inv;
  always_ff @(posedge clk) if (en) begin
    a7_temp <= a6_temp; a7_inv <= a6_inv; a7_po <= a6_po; a7_hh <= a6_hh;
    a7_sq <= 32'($signed(a6_hh) >>> 15) * 32'($signed(a6_hh) >>> 15);
  end
  logic [31:0] a8_temp, a8_hh, a8_m, a8_po;
  logic a8_inv;
  always_ff @(posedge clk) if (en) begin
    a8_temp <= a7_temp; a8_inv <= a7_inv; a8_po <= a7_po; a8_hh <= a7_hh;
    a8_m <= 32'($signed(a7_sq) >>> 7) * h1;
  end
  logic [31:0] a9_h;
  always_comb a9_h = a8_hh - 32'($signed(a8_m) >>> 4);
  logic [31:0] o_temp, o_po;
  logic [16:0] o_hum;
  logic o_inv;
  always_ff @(posedge clk) if (en) begin
    o_temp <= a8_temp; o_po <= a8_po; o_inv <= a8_inv;
    if (a9_h[31]) o_hum <= '0;
    else if (a9_h > HUM_CLAMP_HIGH) o_hum <= 17'(HUM_CLAMP_HIGH >> 12);
    else o_hum <= a9_h[28:12];
  end

  assign out_tdata = {7'd0, o_hum, o_po, o_temp};
  assign out_tuser = o_inv;

  ap_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[80:64] <= 17'd102400)
    else $error("humidity above clamp");
  ap_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[63:32] == 32'd0)
    else $error("invalid pressure not zero");
  ap_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v_r))
    else $error("pipeline moved while stalled");
  ap_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("ready mismatch");

endmodule
`default_nettype wire

// ===== rtl/core/esc_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// esc_div
// Pipelined 64-bit unsigned restoring divider, one quotient bit per stage.
// Carries a side payload alongside; advances when en is high.
// ----------------------------------------------------------------------------
module esc_div #(
  parameter int unsigned SideW = 8
) (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire logic [esc_pkg::DivW-1:0]       num,
  input  wire logic [esc_pkg::DivW-1:0]       den,
  input  wire logic [SideW-1:0]               side_in,
  output logic      [esc_pkg::DivW-1:0]       quo,
  output logic      [SideW-1:0]               side_out
);
  import esc_pkg::*;

  logic [DivW-1:0]  q_r   [1:DivW];
  logic [DivW-1:0]  rem_r [1:DivW];
  logic [DivW-1:0]  d_r   [1:DivW];
  logic [SideW-1:0] s_r   [1:DivW];

  for (genvar i = 0; i < DivW; i++) begin : g_stage
    logic [DivW-1:0]  q_i, rem_i, d_i;
    logic [SideW-1:0] s_i;
    logic [DivW:0]    trial;
    logic [DivW:0]    diff;
    if (i == 0) begin : g_head
      assign q_i   = num;
      assign rem_i = '0;
      assign d_i   = den;
      assign s_i   = side_in;
    end else begin : g_body
      assign q_i   = q_r[i];
      assign rem_i = rem_r[i];
      assign d_i   = d_r[i];
      assign s_i   = s_r[i];
    end
    assign trial = {rem_i, q_i[DivW-1]};
    assign diff  = trial - {1'b0, d_i};
    always_ff @(posedge clk) begin
      if (en) begin
        d_r[i+1] <= d_i;
        s_r[i+1] <= s_i;
        if (!diff[DivW]) begin
          rem_r[i+1] <= diff[DivW-1:0];
          q_r[i+1]   <= {q_i[DivW-2:0], 1'b1};
        end else begin
          rem_r[i+1] <= trial[DivW-1:0];
          q_r[i+1]   <= {q_i[DivW-2:0], 1'b0};
        end
      end
    end
  end

  assign quo      = q_r[DivW];
  assign side_out = s_r[DivW];

endmodule
`default_nettype wire
